// ----- hw/rtl/overlap_rebinning_resampler_macros.svh -----
// Assertion macros shared by the resampler RTL.
// Each check is sampled on aclk and switched off while aresetn is low.
`ifndef OVERLAP_REBINNING_RESAMPLER_MACROS_SVH
`define OVERLAP_REBINNING_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ORR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("orr: same-cycle check failed");
// Next-cycle implication
`define ORR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("orr: next-cycle check failed");
`else
`define ORR_ASSERT_SAME(lbl, ante, cons)
`define ORR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/orr_pkg.sv -----
package orr_pkg;

    // Field and register widths
    localparam int RATIO_W    = 25;
    localparam int OFFSET_W   = 32;
    localparam int COUNT_W    = 11;
    localparam int IDX_W      = 16;
    localparam int SAMPLE_W   = 24;
    localparam int OUT_W      = 48;
    localparam int S_DATA_W   = IDX_W + SAMPLE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Datapath widths: edges are held in units of 1/2^17 input bin
    localparam int FRAC_W  = 17;
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 19;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;
    localparam int EDGE_W  = MUL_W;
    localparam int RANGE_W = EDGE_W - FRAC_W;
    localparam int LEN_W   = FRAC_W + 1;
    localparam int SUM_W   = 50;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_RATIO     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT   = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 25'd65536;

    // Half an input bin and just under it, in edge units
    localparam logic signed [EDGE_W-1:0] HALF_BIN    = 45'sd65536;
    localparam logic signed [EDGE_W-1:0] HALF_BIN_M1 = 45'sd65535;

    // Request kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CENTRE,
        ST_EDGE,
        ST_RANGE,
        ST_CLAMP,
        ST_CHECK,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } orr_state_t;

endpackage

// ----- hw/rtl/orr_ram.sv -----
module orr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/overlap_rebinning_resampler.sv -----
// Load request: one load accepted every cycle while idle. Query request: set-up states
// MUL to CHECK, then a walk of the input bins under the output bin (about bin_ratio/65536
// plus 2, clipped to input_count) and DRAIN, or straight to DONE when no valid bin lies under
// the output bin; the next request is taken in the cycle after the result is loaded.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, registers to
// bin_ratio 1.0, center_offset 0, input_count 0; the sample store is not cleared.
`include "overlap_rebinning_resampler_macros.svh"

module overlap_rebinning_resampler import orr_pkg::*; #(
    parameter int IN_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] bin_index, [39:16] sample
    input  logic                  s_tuser,   // [0] mode
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [47:0] out_value
    output logic                  m_tuser,   // [0] covered
    // register write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

    orr_state_t state_reg, state_next;

    // configuration
    logic        [RATIO_W-1:0]  ratio_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic        [COUNT_W-1:0]  count_reg;

    // request decode
    logic                       s_accept;
    logic        [IDX_W-1:0]    in_idx;
    logic        [SAMPLE_W-1:0] in_sample;
    logic                       in_range;
    logic                       load_we;

    // sequencer controls
    logic issue;
    logic mul_for_centre;
    logic out_load;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_W-1:0]   mul_next;
    logic signed [MUL_W-1:0]   mul_reg;

    // edge set-up
    logic        [IDX_W-1:0]   qidx_reg;
    logic signed [EDGE_W-1:0]  ctr_sum;
    logic signed [EDGE_W-1:0]  ratio_ext;
    logic signed [EDGE_W-1:0]  ctr2_reg;
    logic signed [EDGE_W-1:0]  lo_reg, hi_reg;
    logic signed [EDGE_W-1:0]  first_sum, last_sum;
    logic signed [RANGE_W-1:0] first_reg, last_reg;
    logic signed [RANGE_W-1:0] f_reg, l_reg;
    logic        [CW-1:0]      count_ext, count_eff;
    logic signed [RANGE_W-1:0] cnt_m1;

    // walk
    logic        [AW-1:0]      walk_idx_reg, last_idx_reg;
    logic signed [EDGE_W-1:0]  bin_base, bin_a, bin_b;
    logic signed [EDGE_W-1:0]  left1_reg, right1_reg;
    logic                      v1_reg;
    logic signed [EDGE_W-1:0]  diff;
    logic                      pos;
    logic        [SAMPLE_W-1:0] rd_data;
    logic        [LEN_W-1:0]   len2_reg;
    logic                      pos2_reg, v2_reg;
    logic        [SAMPLE_W-1:0] smp2_reg;
    logic                      pos3_reg, v3_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic                      cov_reg;

    // result
    logic signed [SUM_W-2:0]   half_sum;
    logic        [OUT_W-1:0]   sat_value;
    logic        [OUT_W-1:0]   m_value_reg;
    logic                      m_cov_reg;
    logic                      m_valid_reg;

    assign in_idx    = s_tdata[IDX_W-1:0];
    assign in_sample = s_tdata[S_DATA_W-1:IDX_W];
    assign s_accept  = s_tvalid && s_tready;
    assign in_range  = {1'b0, in_idx} < (IDX_W + 1)'(IN_DEPTH);
    assign load_we   = s_accept && (s_tuser == MODE_LOAD) && in_range;

    // Sample store
    orr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (IN_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (load_we),
        .wr_addr (in_idx[AW-1:0]),
        .wr_data (in_sample),
        .rd_addr (walk_idx_reg),
        .rd_data (rd_data)
    );

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg  <= RATIO_RESET;
            offset_reg <= '0;
            count_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BIN_RATIO:     ratio_reg  <= cfg_wdata[RATIO_W-1:0];
                CFG_CENTER_OFFSET: offset_reg <= $signed(cfg_wdata[OFFSET_W-1:0]);
                CFG_INPUT_COUNT:   count_reg  <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_accept && s_tuser == MODE_QUERY) state_next = ST_MUL;
            ST_MUL:    state_next = ST_CENTRE;
            ST_CENTRE: state_next = ST_EDGE;
            ST_EDGE:   state_next = ST_RANGE;
            ST_RANGE:  state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_CHECK;
            ST_CHECK:  state_next = (f_reg > l_reg) ? ST_DONE : ST_WALK;
            ST_WALK:   if (walk_idx_reg == last_idx_reg) state_next = ST_DRAIN;
            ST_DRAIN:  if (!v1_reg && !v2_reg && !v3_reg) state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready       = 1'b0;
        issue          = 1'b0;
        mul_for_centre = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready       = 1'b1;
            ST_MUL:  mul_for_centre = 1'b1;
            ST_WALK: issue          = 1'b1;
            ST_DONE: out_load       = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Shared multiplier: bin index times ratio, then sample times overlap
    always_comb begin
        if (mul_for_centre) begin
            mul_a = $signed({1'b0, ratio_reg});
            mul_b = $signed({{(MUL_B_W - IDX_W){1'b0}}, qidx_reg});
        end else begin
            mul_a = $signed({{(MUL_A_W - SAMPLE_W){smp2_reg[SAMPLE_W-1]}}, smp2_reg});
            mul_b = $signed({1'b0, len2_reg});
        end
    end
    assign mul_next = mul_a * mul_b;

    // Output bin edges, twice the centre minus and plus the ratio
    assign ctr_sum   = $signed({{(EDGE_W - OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg})
                       + mul_reg;
    assign ratio_ext = $signed({{(EDGE_W - RATIO_W){1'b0}}, ratio_reg});
    assign first_sum = lo_reg + HALF_BIN;
    assign last_sum  = hi_reg + HALF_BIN_M1;

    // Effective count, limited to the store depth
    assign count_ext = CW'(count_reg);
    assign count_eff = (count_ext > CW'(IN_DEPTH)) ? CW'(IN_DEPTH) : count_ext;
    assign cnt_m1    = $signed(RANGE_W'(count_eff)) - $signed(RANGE_W'(1));

    // Current input bin span and overlap with the output bin
    assign bin_base = $signed({{(EDGE_W - AW - FRAC_W){1'b0}}, walk_idx_reg, {FRAC_W{1'b0}}});
    assign bin_a    = bin_base - HALF_BIN;
    assign bin_b    = bin_base + HALF_BIN;
    assign diff     = right1_reg - left1_reg;
    assign pos      = !diff[EDGE_W-1] && (diff != '0);

    // Datapath registers
    always_ff @(posedge aclk) begin
        mul_reg <= mul_next;
        if (s_accept) begin
            qidx_reg <= in_idx;
        end
        // set-up values are held once computed, the walk reads the edges
        if (state_reg == ST_CENTRE) begin
            ctr2_reg <= {ctr_sum[EDGE_W-2:0], 1'b0};
        end
        if (state_reg == ST_EDGE) begin
            lo_reg <= ctr2_reg - ratio_ext;
            hi_reg <= ctr2_reg + ratio_ext;
        end
        if (state_reg == ST_RANGE) begin
            first_reg <= first_sum[EDGE_W-1:FRAC_W];
            last_reg  <= last_sum[EDGE_W-1:FRAC_W];
        end
        if (state_reg == ST_CLAMP) begin
            f_reg <= first_reg[RANGE_W-1] ? '0 : first_reg;
            l_reg <= (last_reg > cnt_m1) ? cnt_m1 : last_reg;
        end

        // walk counter
        if (state_reg == ST_CHECK) begin
            walk_idx_reg <= f_reg[AW-1:0];
            last_idx_reg <= l_reg[AW-1:0];
        end else if (issue && walk_idx_reg != last_idx_reg) begin
            walk_idx_reg <= walk_idx_reg + AW'(1);
        end

        // stage 1: clipped edges
        left1_reg  <= (lo_reg > bin_a) ? lo_reg : bin_a;
        right1_reg <= (hi_reg < bin_b) ? hi_reg : bin_b;
        // stage 2: overlap length, sample from the store
        len2_reg <= pos ? diff[LEN_W-1:0] : '0;
        pos2_reg <= pos;
        smp2_reg <= rd_data;
        // stage 3: product sits in mul_reg
        pos3_reg <= pos2_reg;
        // stage 4: accumulate
        if (s_accept) begin
            acc_reg <= '0;
            cov_reg <= 1'b0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg + $signed({{(SUM_W - MUL_W){mul_reg[MUL_W-1]}}, mul_reg});
            cov_reg <= cov_reg || pos3_reg;
        end

        if (out_load) begin
            m_value_reg <= sat_value;
            m_cov_reg   <= cov_reg;
        end
    end

    // Walk pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Floor to Q.16 and clamp to 48 bits
    assign half_sum = acc_reg[SUM_W-1:1];
    always_comb begin
        if (half_sum[SUM_W-2] != half_sum[OUT_W-1]) begin
            sat_value = half_sum[SUM_W-2] ? {1'b1, {(OUT_W - 1){1'b0}}}
                                           : {1'b0, {(OUT_W - 1){1'b1}}};
        end else begin
            sat_value = half_sum[OUT_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_cov_reg;

    // Checks
    `ORR_ASSERT_NEXT(a_query_starts, s_accept && s_tuser == MODE_QUERY, state_reg == ST_MUL)
    `ORR_ASSERT_NEXT(a_load_single_cycle, s_accept && s_tuser == MODE_LOAD, state_reg == ST_IDLE)
    `ORR_ASSERT_SAME(a_pipe_in_walk, v3_reg, state_reg == ST_WALK || state_reg == ST_DRAIN)
    `ORR_ASSERT_SAME(a_walk_bounded, state_reg == ST_WALK, walk_idx_reg <= last_idx_reg)
    `ORR_ASSERT_SAME(a_uncovered_zero, m_tvalid && !m_tuser, m_tdata == '0)

endmodule
